// ===== hw/rtl/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor packet framer package
// Beat types, command format, framing constants and the CRC16-CCITT byte step.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int unsigned MaskW  = 4;
  localparam int unsigned WordW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CrcW   = 16;
  localparam int unsigned QDepth = 2;

  localparam logic [ByteW-1:0] SYNC0     = 8'h5A;
  localparam logic [ByteW-1:0] SYNC1     = 8'hA5;
  localparam logic [CrcW-1:0]  CRC_INIT  = 16'hFFFF;
  localparam logic [CrcW-1:0]  CRC_POLY  = 16'h1021;
  localparam logic [CrcW-1:0]  CRC_MSB   = 16'h8000;

  localparam logic [2:0] HDR_BYTES  = 3'd5;
  localparam logic [2:0] WORD_BYTES = 3'd4;
  localparam logic [2:0] DROP_BYTES = 3'd1;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  typedef enum logic [1:0] {
    KIND_HDR,
    KIND_DATA,
    KIND_DROP
  } spf_kind_e;

  typedef struct packed {
    logic             operation;
    logic [MaskW-1:0] sensor_mask;
    logic [WordW-1:0] data_word;
  } spf_in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last_of_packet;
    logic             last_of_run;
    logic             status;
  } spf_out_t;

  // header: word = {pad, mask, seq}; data: the block word
  typedef struct packed {
    spf_kind_e        kind;
    logic [WordW-1:0] word;
    logic             crc_after;
  } spf_cmd_t;

  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    int k;
    c = crc ^ {b, 8'h00};
    for (k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != '0) begin
        c = {c[CrcW-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/spf_front.sv =====
// ----------------------------------------------------------------------------
// Sensor packet framer front end
// Classifies input beats, tracks packet state and issues byte-run commands.
// ----------------------------------------------------------------------------
module spf_front #(
  parameter int unsigned SENSOR_COUNT    = 4,
  parameter int unsigned WORDS_PER_BLOCK = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  spf_pkg::spf_in_t  item_i,
  output spf_pkg::spf_cmd_t cmd_o
);
  import spf_pkg::*;

  localparam int unsigned WrW = $clog2(SENSOR_COUNT * WORDS_PER_BLOCK + 1);

  logic [CrcW-1:0]  seq_q, seq_d;
  logic [WrW-1:0]   words_q, words_d;
  logic             open_q, open_d;
  logic [MaskW-1:0] keep, mask;
  logic [3:0]       bits;
  logic [31:0]      prod;
  logic [WrW-1:0]   total;

  always_comb begin
    for (int i = 0; i < MaskW; i++) begin
      keep[i] = (i < SENSOR_COUNT);
    end
  end

  assign mask  = item_i.sensor_mask & keep;
  assign bits  = 4'(mask[0]) + 4'(mask[1]) + 4'(mask[2]) + 4'(mask[3]);
  assign prod  = 32'(bits) * 32'(WORDS_PER_BLOCK);
  assign total = prod[WrW-1:0];

  always_comb begin
    seq_d   = seq_q;
    words_d = words_q;
    open_d  = open_q;
    cmd_o.kind      = KIND_DROP;
    cmd_o.word      = item_i.data_word;
    cmd_o.crc_after = 1'b0;
    if (item_i.operation == OP_BEGIN) begin
      cmd_o.kind      = KIND_HDR;
      cmd_o.word      = {8'h00, 4'h0, mask, seq_q};
      cmd_o.crc_after = (total == '0);
      seq_d   = seq_q + 16'd1;
      words_d = total;
      open_d  = (total != '0);
    end else if (open_q) begin
      cmd_o.kind      = KIND_DATA;
      cmd_o.crc_after = (words_q == WrW'(1));
      words_d = words_q - WrW'(1);
      open_d  = (words_q != WrW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= '0;
      words_q <= '0;
      open_q  <= 1'b0;
    end else if (acc_i) begin
      seq_q   <= seq_d;
      words_q <= words_d;
      open_q  <= open_d;
    end
  end

endmodule

// ===== hw/rtl/spf_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Sensor packet framer command queue
// Short register queue between the front end and the byte engine.
// ----------------------------------------------------------------------------
module spf_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  spf_pkg::spf_cmd_t wdata_i,
  input  logic              rd_i,
  output spf_pkg::spf_cmd_t rdata_o,
  output logic              full_o,
  output logic              empty_o
);
  import spf_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  spf_cmd_t        mem_q [QDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= (wptr_q == PtrW'(QDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (rd_i) begin
        rptr_q <= (rptr_q == PtrW'(QDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/spf_back.sv =====
// ----------------------------------------------------------------------------
// Sensor packet framer byte engine
// Runs commands out one byte per cycle while the result register is free or
// being popped, keeps the running CRC, owns the result register.
// ----------------------------------------------------------------------------
module spf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  spf_pkg::spf_cmd_t cmd_i,
  output logic              cmd_take_o,
  input  logic              pop_i,
  output logic              empty_o,
  output spf_pkg::spf_out_t item_o
);
  import spf_pkg::*;

  logic [2:0]       idx_q, idx_d;
  logic [CrcW-1:0]  crc_q, crc_base;
  logic             vld_q;
  spf_out_t         out_q, beat;
  logic [2:0]       n_pay;
  logic             can_load, emit, in_crc, last;

  assign can_load = !vld_q || pop_i;
  assign emit     = cmd_valid_i && can_load;

  always_comb begin
    case (cmd_i.kind)
      KIND_HDR:  n_pay = HDR_BYTES;
      KIND_DATA: n_pay = WORD_BYTES;
      default:   n_pay = DROP_BYTES;
    endcase
    in_crc = cmd_i.crc_after && (idx_q >= n_pay);
    last   = cmd_i.crc_after ? (idx_q == n_pay + 3'd1) : (idx_q == n_pay - 3'd1);
    beat.last_of_run    = last;
    beat.last_of_packet = cmd_i.crc_after && last;
    beat.status         = 1'b0;
    beat.out_byte       = '0;
    if (in_crc) begin
      beat.out_byte = (idx_q == n_pay) ? crc_q[15:8] : crc_q[7:0];
    end else begin
      case (cmd_i.kind)
        KIND_HDR: begin
          case (idx_q)
            3'd0:    beat.out_byte = SYNC0;
            3'd1:    beat.out_byte = SYNC1;
            3'd2:    beat.out_byte = cmd_i.word[7:0];
            3'd3:    beat.out_byte = cmd_i.word[15:8];
            default: beat.out_byte = cmd_i.word[23:16];
          endcase
        end
        KIND_DATA: begin
          case (idx_q)
            3'd0:    beat.out_byte = cmd_i.word[7:0];
            3'd1:    beat.out_byte = cmd_i.word[15:8];
            3'd2:    beat.out_byte = cmd_i.word[23:16];
            default: beat.out_byte = cmd_i.word[31:24];
          endcase
        end
        default: beat.status = 1'b1;
      endcase
    end
    crc_base   = (cmd_i.kind == KIND_HDR && idx_q == 3'd0) ? CRC_INIT : crc_q;
    idx_d      = last ? 3'd0 : idx_q + 3'd1;
    cmd_take_o = emit && last;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
      crc_q <= CRC_INIT;
    end else begin
      if (can_load) begin
        vld_q <= emit;
      end
      if (emit) begin
        idx_q <= idx_d;
        if (!in_crc && cmd_i.kind != KIND_DROP) begin
          crc_q <= crc_byte(crc_base, beat.out_byte);
        end
      end
    end
  end

  assign empty_o = !vld_q;
  assign item_o  = out_q;

endmodule

// ===== hw/rtl/sensor_packet_framer_crc16_core.sv =====
// ----------------------------------------------------------------------------
// Sensor packet framer with CRC16-CCITT
// An accepted item passes the command queue, then the result register, to the port.
// Throughput: one byte per cycle from the byte engine unless output stalls;
//   a data beat is 4 bytes (6 if the CRC closes the packet), a begin 5 (7), a drop 1.
// Input is held off only when the 2-entry command queue is full.
// Reset (async, active low): sequence 0, no open packet, queues empty.
// ----------------------------------------------------------------------------
module sensor_packet_framer_crc16_core #(
  parameter int unsigned SENSOR_COUNT    = 4,
  parameter int unsigned WORDS_PER_BLOCK = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  spf_pkg::spf_in_t in_item_i,
  output logic             empty,
  input  logic             pop,
  output spf_pkg::spf_out_t out_item_o
);
  import spf_pkg::*;

  spf_cmd_t cmd_wr, cmd_rd;
  logic     acc, q_empty, take;

  assign acc = push && !full;

  spf_front #(
    .SENSOR_COUNT    (SENSOR_COUNT),
    .WORDS_PER_BLOCK (WORDS_PER_BLOCK)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .item_i (in_item_i),
    .cmd_o  (cmd_wr)
  );

  spf_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (acc),
    .wdata_i (cmd_wr),
    .rd_i    (take),
    .rdata_o (cmd_rd),
    .full_o  (full),
    .empty_o (q_empty)
  );

  spf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (cmd_rd),
    .cmd_take_o  (take),
    .pop_i       (pop),
    .empty_o     (empty),
    .item_o      (out_item_o)
  );

endmodule

// ===== hw/rtl/spf_checker.sv =====
// ----------------------------------------------------------------------------
// Sensor packet framer port checker
// Port-level properties of the framer, bound to the top level.
// ----------------------------------------------------------------------------
module spf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input spf_pkg::spf_out_t out_item_o
);
  import spf_pkg::*;

  a_lastp_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.last_of_packet) |-> out_item_o.last_of_run)
    else $error("packet end beat not marked as end of run");

  a_drop_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.status) |->
      (out_item_o.last_of_run && !out_item_o.last_of_packet &&
       out_item_o.out_byte == '0))
    else $error("malformed drop beat");

  a_full_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("input stalled while result side idle");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("stalled result beat changed");

endmodule

bind sensor_packet_framer_crc16_core spf_checker u_spf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
